// ----- src/cms4_pkg.sv -----
`default_nettype none

package cms4_pkg;

  // Default geometry of the sketch
  localparam int ROWS_DEF = 4;
  localparam int COUNTERS_PER_ROW_DEF = 1024;

  // Seed registers and configuration index width
  localparam int SEED_REGS = 4;
  localparam int CFG_IDX_W = 3;
  localparam int SEED_W = 32;

  // Counter width and saturation value
  localparam int CNT_W = 4;
  localparam logic [CNT_W-1:0] CNT_MAX = 4'd15;

  // Request kinds
  typedef enum logic [1:0] {
    KIND_INC   = 2'd0,
    KIND_EST   = 2'd1,
    KIND_HALVE = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCAN,
    ST_SWEEP,
    ST_CLEAR,
    ST_DRAIN,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

// ----- src/count_min_sketch_4bit.sv -----
// Count-min sketch with 4-bit saturating counters.
// Input channel (in_valid_i/in_ready_o) carries one request: kind_i and
// hash_value_i. Output channel (out_valid_o/out_ready_i) returns exactly one
// count_estimate_o per request: the row minimum for an estimate, zero otherwise.
// All counters live in one single-port-read, single-port-write memory of
// ROWS*COUNTERS_PER_ROW entries; rows are visited one per cycle.
// Increment and estimate: one read per row (write-back of the previous row
// overlaps the next read), then the drain state and the done state, which
// loads the output register; a new request is taken only back in idle.
// Halve: one read per counter, with write-back of the halved value.
// Clear: one write per counter.
// Reset: seeds go to zero and a clearing pass writes zero to every counter,
// with in_ready_o low; seed writes are taken.
// Seeds are written through cfg_we_i/cfg_idx_i/cfg_data_i, by the user only
// while idle (not enforced by the block); indexes above three are ignored.
// A stalled receiver holds the result in the output register; the block
// still takes the next request and finishes it, then waits until the output
// register is free before presenting the new result.
`default_nettype none

module count_min_sketch_4bit #(
  parameter int ROWS = cms4_pkg::ROWS_DEF,
  parameter int COUNTERS_PER_ROW = cms4_pkg::COUNTERS_PER_ROW_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // configuration
  input  wire logic                           cfg_we_i,
  input  wire logic [cms4_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [cms4_pkg::SEED_W-1:0]    cfg_data_i,
  // request channel
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [1:0]                     kind_i,
  input  wire logic [31:0]                    hash_value_i,
  // result channel
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [cms4_pkg::CNT_W-1:0]          count_estimate_o
);

  localparam int Depth = ROWS * COUNTERS_PER_ROW;
  localparam int RowW  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int ColW  = $clog2(COUNTERS_PER_ROW);
  localparam int AddrW = $clog2(Depth);
  localparam int CntW  = cms4_pkg::CNT_W;
  localparam logic [ColW-1:0]  ColMask  = ColW'(COUNTERS_PER_ROW - 1);
  localparam logic [AddrW-1:0] RowStep  = AddrW'(COUNTERS_PER_ROW);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);
  localparam logic [RowW-1:0]  LastRow  = RowW'(ROWS - 1);

  // Registers
  cms4_pkg::state_e state_q, state_d;
  cms4_pkg::kind_e  op_q, op_d;
  logic [31:0]      hash_q, hash_d;
  logic [RowW-1:0]  row_q, row_d;
  logic [AddrW-1:0] base_q, base_d;
  logic [AddrW-1:0] addr_q, addr_d;
  logic [CntW-1:0]  min_q, min_d;
  logic             rd_vld_q, rd_vld_d;
  logic [AddrW-1:0] rd_addr_q;
  logic             out_valid_q, out_valid_d;
  logic [CntW-1:0]  out_data_q, out_data_d;
  logic [cms4_pkg::SEED_W-1:0] seed_q [cms4_pkg::SEED_REGS];

  // Memory port signals
  logic             mem_re;
  logic [AddrW-1:0] mem_raddr;
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [CntW-1:0]  mem_wdata;
  logic [CntW-1:0]  rdata_q;
  logic [CntW-1:0]  mem [Depth];

  // Row address generation
  logic [RowW:0]    row_ext;
  logic [1:0]       seed_sel;
  logic [ColW-1:0]  scan_col;
  logic [AddrW-1:0] scan_addr;
  logic [CntW-1:0]  wb_data;

  assign row_ext   = {1'b0, row_q};
  assign seed_sel  = row_ext[1:0];
  assign scan_col  = (hash_q[ColW-1:0] ^ seed_q[seed_sel][ColW-1:0]) & ColMask;
  assign scan_addr = base_q + AddrW'(scan_col);

  // Modified value for write-back
  always_comb begin
    if (op_q == cms4_pkg::KIND_HALVE) begin
      wb_data = {1'b0, rdata_q[CntW-1:1]};
    end else if (rdata_q == cms4_pkg::CNT_MAX) begin
      wb_data = rdata_q;
    end else begin
      wb_data = rdata_q + CntW'(1);
    end
  end

  // Seed registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < cms4_pkg::SEED_REGS; k++) begin
        seed_q[k] <= '0;
      end
    end else if (cfg_we_i &&
                 cfg_idx_i < cms4_pkg::CFG_IDX_W'(cms4_pkg::SEED_REGS)) begin
      seed_q[cfg_idx_i[1:0]] <= cfg_data_i;
    end
  end

  // Counter memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  // Sequencer next state and memory control
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    hash_d      = hash_q;
    row_d       = row_q;
    base_d      = base_q;
    addr_d      = addr_q;
    min_d       = min_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    mem_re      = 1'b0;
    mem_raddr   = scan_addr;
    mem_we      = 1'b0;
    mem_waddr   = rd_addr_q;
    mem_wdata   = wb_data;

    // write-back / min update of the word read last cycle
    if (rd_vld_q) begin
      if (op_q == cms4_pkg::KIND_INC || op_q == cms4_pkg::KIND_HALVE) begin
        mem_we = 1'b1;
      end else if (op_q == cms4_pkg::KIND_EST && rdata_q < min_q) begin
        min_d = rdata_q;
      end
    end

    unique case (state_q)
      cms4_pkg::ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = addr_q;
        mem_wdata = '0;
        addr_d    = addr_q + AddrW'(1);
        if (addr_q == LastAddr) begin
          addr_d  = '0;
          state_d = cms4_pkg::ST_IDLE;
        end
      end
      cms4_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          op_d   = cms4_pkg::kind_e'(kind_i);
          hash_d = hash_value_i;
          row_d  = '0;
          base_d = '0;
          addr_d = '0;
          min_d  = cms4_pkg::CNT_MAX;
          unique case (cms4_pkg::kind_e'(kind_i))
            cms4_pkg::KIND_INC,
            cms4_pkg::KIND_EST:   state_d = cms4_pkg::ST_SCAN;
            cms4_pkg::KIND_HALVE: state_d = cms4_pkg::ST_SWEEP;
            default:              state_d = cms4_pkg::ST_CLEAR;
          endcase
        end
      end
      cms4_pkg::ST_SCAN: begin
        mem_re    = 1'b1;
        mem_raddr = scan_addr;
        row_d     = row_q + RowW'(1);
        base_d    = base_q + RowStep;
        if (row_q == LastRow) begin
          state_d = cms4_pkg::ST_DRAIN;
        end
      end
      cms4_pkg::ST_SWEEP: begin
        mem_re    = 1'b1;
        mem_raddr = addr_q;
        addr_d    = addr_q + AddrW'(1);
        if (addr_q == LastAddr) begin
          state_d = cms4_pkg::ST_DRAIN;
        end
      end
      cms4_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = addr_q;
        mem_wdata = '0;
        addr_d    = addr_q + AddrW'(1);
        if (addr_q == LastAddr) begin
          state_d = cms4_pkg::ST_DONE;
        end
      end
      cms4_pkg::ST_DRAIN: begin
        state_d = cms4_pkg::ST_DONE;
      end
      cms4_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = (op_q == cms4_pkg::KIND_EST) ? min_q : '0;
          state_d     = cms4_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = cms4_pkg::ST_IDLE;
      end
    endcase

    rd_vld_d = mem_re;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cms4_pkg::ST_INIT;
      addr_q      <= '0;
      row_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      addr_q      <= addr_d;
      row_q       <= row_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    hash_q     <= hash_d;
    base_q     <= base_d;
    min_q      <= min_d;
    rd_addr_q  <= mem_raddr;
    out_data_q <= out_data_d;
  end

  assign in_ready_o       = (state_q == cms4_pkg::ST_IDLE);
  assign out_valid_o      = out_valid_q;
  assign count_estimate_o = out_data_q;

`ifndef SYNTHESIS
  // read and write never hit the same entry in one cycle
  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("counter memory read and write collide");

  // no write-back is pending when a new request can be taken
  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !rd_vld_q)
    else $error("write-back pending while idle");

  // no result appears during the reset clearing pass
  a_init_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cms4_pkg::ST_INIT) |-> !out_valid_q)
    else $error("result valid during clearing pass");

  // scan never runs past the last row
  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cms4_pkg::ST_SCAN) |-> (row_q <= LastRow))
    else $error("row counter out of range");

  // a result is loaded only when leaving the done state
  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_q || out_ready_i) && out_valid_d |-> (state_q == cms4_pkg::ST_DONE))
    else $error("result loaded outside done state");
`endif

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NROWS = cms4_pkg::ROWS_DEF;
  localparam int NCOLS = cms4_pkg::COUNTERS_PER_ROW_DEF;
  localparam int COL_MASK = NCOLS - 1;
  localparam int NUM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int SETTLE_CYCLES = 16;
  // longest quiet stretch: a full halve sweep plus stalls, taken several times over
  localparam int WATCHDOG_LIMIT = 40000;

  // handshake pacing per phase
  typedef enum int {
    PACE_FULL,
    PACE_SLOW_SEND,
    PACE_SLOW_RECV,
    PACE_BOTH
  } pace_e;

  typedef struct {
    cms4_pkg::kind_e            kind;
    logic [cms4_pkg::CNT_W-1:0] est;
  } est_entry_t;

  typedef struct packed {
    cms4_pkg::kind_e            kind;
    logic [31:0]                hash;
    int                         reps;
    bit                         known;
    logic [cms4_pkg::CNT_W-1:0] est;
  } dir_row_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [cms4_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [cms4_pkg::SEED_W-1:0]    cfg_data_i;
  logic                           in_valid_i;
  logic                           in_ready_o;
  logic [1:0]                     kind_i;
  logic [31:0]                    hash_value_i;
  logic                           out_valid_o;
  logic                           out_ready_i;
  logic [cms4_pkg::CNT_W-1:0]     count_estimate_o;

  // sketch mirror used for prediction
  logic [cms4_pkg::CNT_W-1:0]  sketch_cnt [NROWS][NCOLS];
  logic [cms4_pkg::SEED_W-1:0] row_seed [cms4_pkg::SEED_REGS];

  est_entry_t estimate_queue [$];
  int         mismatch_count;
  int         quiet_cycles;
  int         send_idle_pct;
  int         stall_pct;

  // seeds are zero here, so each hash hits the same column in every row
  dir_row_t dir_table [10] = '{
    '{cms4_pkg::KIND_EST,   32'h0000_0000, 1,  1'b1, 4'd0},
    '{cms4_pkg::KIND_INC,   32'h0000_0000, 1,  1'b1, 4'd0},
    '{cms4_pkg::KIND_EST,   32'h0000_0000, 1,  1'b1, 4'd1},
    '{cms4_pkg::KIND_INC,   32'hFFFF_FFFF, 16, 1'b1, 4'd0},  // last one hits saturation
    '{cms4_pkg::KIND_EST,   32'hFFFF_FFFF, 1,  1'b1, 4'd15},
    '{cms4_pkg::KIND_HALVE, 32'h0000_0000, 1,  1'b1, 4'd0},
    '{cms4_pkg::KIND_EST,   32'hFFFF_FFFF, 1,  1'b1, 4'd7},
    '{cms4_pkg::KIND_EST,   32'h0000_0000, 1,  1'b1, 4'd0},
    '{cms4_pkg::KIND_CLEAR, 32'hFFFF_FFFF, 1,  1'b1, 4'd0},
    '{cms4_pkg::KIND_EST,   32'hFFFF_FFFF, 1,  1'b1, 4'd0}
  };

  count_min_sketch_4bit i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .kind_i          (kind_i),
    .hash_value_i    (hash_value_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .count_estimate_o(count_estimate_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // apply one request to the mirror, return the estimate it yields
  function automatic logic [cms4_pkg::CNT_W-1:0] sketch_apply(cms4_pkg::kind_e k,
                                                              logic [31:0] h);
    logic [cms4_pkg::CNT_W-1:0] est;
    int col;
    est = '0;
    case (k)
      cms4_pkg::KIND_INC: begin
        for (int r = 0; r < NROWS; r++) begin
          col = int'((h ^ row_seed[r % cms4_pkg::SEED_REGS]) & COL_MASK);
          if (sketch_cnt[r][col] != cms4_pkg::CNT_MAX)
            sketch_cnt[r][col] = sketch_cnt[r][col] + 1'b1;
        end
      end
      cms4_pkg::KIND_EST: begin
        est = cms4_pkg::CNT_MAX;
        for (int r = 0; r < NROWS; r++) begin
          col = int'((h ^ row_seed[r % cms4_pkg::SEED_REGS]) & COL_MASK);
          if (sketch_cnt[r][col] < est) est = sketch_cnt[r][col];
        end
      end
      cms4_pkg::KIND_HALVE: begin
        for (int r = 0; r < NROWS; r++)
          for (int c = 0; c < NCOLS; c++)
            sketch_cnt[r][c] = (sketch_cnt[r][c] >> 1) & 4'h7;
      end
      default: begin
        for (int r = 0; r < NROWS; r++)
          for (int c = 0; c < NCOLS; c++)
            sketch_cnt[r][c] = '0;
      end
    endcase
    return est;
  endfunction

  task automatic flag_mismatch(string what, logic [cms4_pkg::CNT_W-1:0] want,
                               logic [cms4_pkg::CNT_W-1:0] got);
    $display("mismatch at %0t: %s, expected %0d got %0d", $realtime, what, want, got);
    mismatch_count++;
  endtask

  // called at a falling edge, returns at the falling edge after the handshake
  task automatic push_request(cms4_pkg::kind_e k, logic [31:0] h, bit known,
                              logic [cms4_pkg::CNT_W-1:0] known_est);
    est_entry_t entry;
    logic [cms4_pkg::CNT_W-1:0] model_est;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i   = 1'b0;
      kind_i       = 2'($urandom_range(0, 3));
      hash_value_i = $urandom;
      @(negedge clk_i);
    end
    in_valid_i   = 1'b1;
    kind_i       = k;
    hash_value_i = h;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    model_est  = sketch_apply(k, h);
    entry.kind = k;
    entry.est  = known ? known_est : model_est;
    estimate_queue.push_back(entry);
    @(negedge clk_i);
  endtask

  // drain all outstanding results and let the block go idle
  task automatic settle();
    in_valid_i = 1'b0;
    while (estimate_queue.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_pace(pace_e pace);
    case (pace)
      PACE_FULL:      begin send_idle_pct = 0;  stall_pct = 0;  end
      PACE_SLOW_SEND: begin send_idle_pct = 79; stall_pct = 0;  end
      PACE_SLOW_RECV: begin send_idle_pct = 0;  stall_pct = 79; end
      default:        begin send_idle_pct = 19; stall_pct = 19; end
    endcase
  endtask

  // all eight indexes are written; those past the seeds must be ignored
  task automatic load_seeds(int phase);
    logic [cms4_pkg::SEED_W-1:0] v;
    for (int i = 0; i < (1 << cms4_pkg::CFG_IDX_W); i++) begin
      case (phase)
        1:       v = '1;
        3:       v = '0;
        4:       v = (i == 1) ? row_seed[0] : $urandom;  // two rows share a column
        default: v = $urandom;
      endcase
      cfg_we_i   = 1'b1;
      cfg_idx_i  = cms4_pkg::CFG_IDX_W'(i);
      cfg_data_i = v;
      if (i < cms4_pkg::SEED_REGS) row_seed[i] = v;
      @(negedge clk_i);
    end
    cfg_we_i = 1'b0;
  endtask

  // mostly traffic on a few hot keys so counters climb, saturate and age
  task automatic run_hot_keys();
    logic [31:0] keys [4];
    logic [31:0] h;
    cms4_pkg::kind_e k;
    int pick;
    keys[0] = $urandom;
    keys[1] = $urandom;
    keys[2] = keys[0] ^ ($urandom << 10);  // same column as keys[0] in every row
    keys[3] = $urandom;
    repeat (ITEMS_PER_PHASE) begin
      pick = $urandom_range(0, 99);
      h    = (pick < 84) ? keys[$urandom_range(0, 3)] : $urandom;
      if (pick < 52 || (pick >= 84 && pick < 90)) k = cms4_pkg::KIND_INC;
      else if (pick < 96)                          k = cms4_pkg::KIND_EST;
      else if (pick < 98)                          k = cms4_pkg::KIND_HALVE;
      else                                         k = cms4_pkg::KIND_CLEAR;
      push_request(k, h, 1'b0, '0);
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    est_entry_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (estimate_queue.size() == 0) begin
        flag_mismatch("result with no request pending", '0, count_estimate_o);
      end else begin
        want = estimate_queue.pop_front();
        if (count_estimate_o !== want.est)
          flag_mismatch($sformatf("count_estimate for %s", want.kind.name()), want.est,
                        count_estimate_o);
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk_i) begin
    out_ready_i = ($urandom_range(0, 99) >= stall_pct);
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    kind_i         = cms4_pkg::KIND_INC;
    hash_value_i   = '0;
    out_ready_i    = 1'b0;
    mismatch_count = 0;
    quiet_cycles   = 0;
    set_pace(PACE_FULL);
    for (int i = 0; i < cms4_pkg::SEED_REGS; i++) row_seed[i] = '0;
    for (int r = 0; r < NROWS; r++)
      for (int c = 0; c < NCOLS; c++)
        sketch_cnt[r][c] = '0;

    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed checks with reset seeds
    foreach (dir_table[n])
      repeat (dir_table[n].reps)
        push_request(dir_table[n].kind, dir_table[n].hash, dir_table[n].known, dir_table[n].est);

    // random phases, each with its own seeds and pacing
    for (int p = 1; p <= NUM_PHASES; p++) begin
      settle();
      set_pace(pace_e'((p - 1) % 4));
      load_seeds(p);
      run_hot_keys();
    end
    settle();

    if (mismatch_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire
